FILE: src/amhpq_pkg.sv
// ============================================================================
// amhpq_pkg
// Shared types and codes for the absolute-value min-heap priority queue.
// ============================================================================
`default_nettype none

package amhpq_pkg;

    localparam int KEY_W          = 32;
    localparam int HEAP_DEPTH_DEF = 1024;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic                    t_req;

    localparam t_req REQ_INSERT  = 1'b0;
    localparam t_req REQ_EXTRACT = 1'b1;

endpackage

`default_nettype wire

FILE: src/amhpq_if.sv
// ============================================================================
// amhpq_if
// Valid/ready channels for request words and response words.
// ============================================================================
`default_nettype none

interface amhpq_req_if;
    import amhpq_pkg::*;

    logic valid;
    logic ready;
    t_req req_type;
    t_key key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface amhpq_rsp_if;
    import amhpq_pkg::*;

    logic valid;
    logic ready;
    t_key min_key;
    logic was_empty;

    modport source (output valid, output min_key, output was_empty, input ready);
    modport sink   (input valid, input min_key, input was_empty, output ready);
endinterface

`default_nettype wire

FILE: src/amhpq_cmp.sv
// ============================================================================
// amhpq_cmp
// Key order unit: a orders before b by absolute value, then by signed value.
// ============================================================================
`default_nettype none

module amhpq_cmp (
    input  wire amhpq_pkg::t_key i_a,
    input  wire amhpq_pkg::t_key i_b,
    output logic                 o_before
);
    import amhpq_pkg::*;

    logic [KEY_W-1:0] w_mag_a;
    logic [KEY_W-1:0] w_mag_b;

    // The most negative key maps to 2^31 as an unsigned magnitude.
    assign w_mag_a = i_a[KEY_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b = i_b[KEY_W-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        if (w_mag_a != w_mag_b) begin
            o_before = (w_mag_a < w_mag_b);
        end else begin
            o_before = (i_a < i_b);
        end
    end

endmodule

`default_nettype wire

FILE: src/abs_min_heap_priority_queue_unit.sv
// ============================================================================
// abs_min_heap_priority_queue_unit
// Binary min-heap priority queue ordered by (|key|, key), one word at a time.
// ============================================================================
// Operation: an insert climbs level by level, reading and comparing each
// parent; an extract reads the root and the last entry, then sinks level by
// level, reading one or two children and comparing; an empty extract skips
// the memory and a full heap drops an insert; an extract waits while the
// output register is full. One word per operation; one memory read and one
// shared compare per step set the cost. Reset clears count and control only.
`default_nettype none

module abs_min_heap_priority_queue_unit #(
    parameter int HEAP_DEPTH = amhpq_pkg::HEAP_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    amhpq_req_if.sink   i_req,
    amhpq_rsp_if.source o_rsp
);
    import amhpq_pkg::*;

    // Address and count share one width: the heap holds HEAP_DEPTH - 1 keys
    // in slots 1 .. count, and slot 0 is never used.
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam logic [AW-1:0] FULL_COUNT = AW'(HEAP_DEPTH - 1);
    localparam logic [AW-1:0] ROOT       = AW'(1);

    // Sequencer codes.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INS_RD  = 4'd1;
    localparam logic [3:0] ST_INS_CMP = 4'd2;
    localparam logic [3:0] ST_EX_TOP  = 4'd3;
    localparam logic [3:0] ST_EX_LAST = 4'd4;
    localparam logic [3:0] ST_EX_RDC  = 4'd5;
    localparam logic [3:0] ST_EX_C1   = 4'd6;
    localparam logic [3:0] ST_EX_CMP2 = 4'd7;
    localparam logic [3:0] ST_EX_CMP  = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    // Heap memory: one write and one registered read per cycle.
    t_key          r_mem [HEAP_DEPTH];
    t_key          r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_key          w_wdata;
    logic [AW-1:0] w_raddr;

    // Control and datapath registers.
    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx,   n_idx;    // insert hole, or extract parent
    logic [AW:0]   r_child, n_child;  // one bit wider: 2 * parent may overflow
    t_key          r_key,   n_key;    // key being inserted
    t_key          r_last,  n_last;   // last entry sinking from the root
    t_key          r_top,   n_top;    // key to return
    t_key          r_cval,  n_cval;   // smaller child seen so far
    logic          r_empty, n_empty;

    // Output register, so a finished word can wait while the next one starts.
    logic          r_ovalid, n_ovalid;
    t_key          r_omin,   n_omin;
    logic          r_oempty, n_oempty;

    // The one shared comparator and its operand selection.
    t_key w_cmp_a;
    t_key w_cmp_b;
    logic w_before;
    logic w_out_free;

    amhpq_cmp u_cmp (
        .i_a      (w_cmp_a),
        .i_b      (w_cmp_b),
        .o_before (w_before)
    );

    always_comb begin
        case (r_state)
            ST_INS_CMP: begin
                w_cmp_a = r_key;
                w_cmp_b = r_rdata;
            end
            ST_EX_CMP2: begin
                w_cmp_a = r_rdata;
                w_cmp_b = r_cval;
            end
            default: begin
                w_cmp_a = r_cval;
                w_cmp_b = r_last;
            end
        endcase
    end

    assign w_out_free = !r_ovalid || o_rsp.ready;

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.min_key   = r_omin;
    assign o_rsp.was_empty = r_oempty;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_child  = r_child;
        n_key    = r_key;
        n_last   = r_last;
        n_top    = r_top;
        n_cval   = r_cval;
        n_empty  = r_empty;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_omin   = r_omin;
        n_oempty = r_oempty;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = r_last;
        w_raddr  = ROOT;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_INSERT) begin
                        // A full heap drops the key silently.
                        if (r_count != FULL_COUNT) begin
                            n_count = r_count + 1'b1;
                            n_idx   = r_count + 1'b1;
                            n_key   = i_req.key_value;
                            n_state = ST_INS_RD;
                        end
                    end else if (r_count == '0) begin
                        n_top   = '0;
                        n_empty = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        // The root read is issued now and lands next cycle.
                        n_empty = 1'b0;
                        n_count = r_count - 1'b1;
                        w_raddr = ROOT;
                        n_state = ST_EX_TOP;
                    end
                end
            end

            ST_INS_RD: begin
                if (r_idx == ROOT) begin
                    w_we    = 1'b1;
                    w_waddr = ROOT;
                    w_wdata = r_key;
                    n_state = ST_IDLE;
                end else begin
                    w_raddr = r_idx >> 1;
                    n_state = ST_INS_CMP;
                end
            end

            ST_INS_CMP: begin
                // Move the parent down into the hole, or settle the key here.
                w_we    = 1'b1;
                w_waddr = r_idx;
                if (w_before) begin
                    w_wdata = r_rdata;
                    n_idx   = r_idx >> 1;
                    n_state = ST_INS_RD;
                end else begin
                    w_wdata = r_key;
                    n_state = ST_IDLE;
                end
            end

            ST_EX_TOP: begin
                // The count is already one less, so the last slot is count + 1.
                n_top   = r_rdata;
                w_raddr = r_count + 1'b1;
                n_idx   = ROOT;
                n_child = (AW+1)'(2);
                n_state = ST_EX_LAST;
            end

            ST_EX_LAST: begin
                n_last  = r_rdata;
                n_state = ST_EX_RDC;
            end

            ST_EX_RDC: begin
                if (r_child > {1'b0, r_count}) begin
                    n_state = ST_FIN;
                end else begin
                    w_raddr = r_child[AW-1:0];
                    n_state = ST_EX_C1;
                end
            end

            ST_EX_C1: begin
                n_cval = r_rdata;
                if (r_child < {1'b0, r_count}) begin
                    w_raddr = r_child[AW-1:0] + 1'b1;
                    n_state = ST_EX_CMP2;
                end else begin
                    n_state = ST_EX_CMP;
                end
            end

            ST_EX_CMP2: begin
                // Right child wins only when strictly before the left one.
                if (w_before) begin
                    n_cval  = r_rdata;
                    n_child = r_child + 1'b1;
                end
                n_state = ST_EX_CMP;
            end

            ST_EX_CMP: begin
                if (!w_before) begin
                    n_state = ST_FIN;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_idx;
                    w_wdata = r_cval;
                    n_idx   = r_child[AW-1:0];
                    n_child = {r_child[AW-1:0], 1'b0};
                    n_state = ST_EX_RDC;
                end
            end

            ST_FIN: begin
                // Wait here until the output register can take the word.
                if (w_out_free) begin
                    w_we     = (r_count != '0);
                    w_waddr  = r_idx;
                    w_wdata  = r_last;
                    n_ovalid = 1'b1;
                    n_omin   = r_top;
                    n_oempty = r_empty;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_child  <= n_child;
        r_key    <= n_key;
        r_last   <= n_last;
        r_top    <= n_top;
        r_cval   <= n_cval;
        r_empty  <= n_empty;
        r_omin   <= n_omin;
        r_oempty <= n_oempty;
    end

endmodule

`default_nettype wire

FILE: src/amhpq_chk.sv
// ============================================================================
// amhpq_chk
// Port-level checks for the heap priority queue, bound to the top level.
// ============================================================================
`default_nettype none

module amhpq_chk (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_req_valid,
    input wire                  i_req_ready,
    input wire amhpq_pkg::t_req i_req_type,
    input wire                  i_rsp_valid,
    input wire                  i_rsp_ready,
    input wire amhpq_pkg::t_key i_rsp_min_key,
    input wire                  i_rsp_was_empty
);
    import amhpq_pkg::*;

    // A stalled response word stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response word dropped while stalled");

    // A stalled response word keeps its payload.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_min_key) && $stable(i_rsp_was_empty))
        else $error("response payload changed while stalled");

    // An empty-heap answer always carries a zero key.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_was_empty |-> i_rsp_min_key == '0)
        else $error("empty response with nonzero key");

    // An accepted extract leaves the block busy in the cycle after it.
    a_extract_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_type == REQ_EXTRACT |=> !i_req_ready)
        else $error("ready held through an extract");

endmodule

bind abs_min_heap_priority_queue_unit amhpq_chk u_amhpq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_type      (i_req.req_type),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_min_key   (o_rsp.min_key),
    .i_rsp_was_empty (o_rsp.was_empty)
);

`default_nettype wire
